[hw/rtl/strm_pkg.sv]
// Shared types, constants and helper functions for the sparse-table
// range-minimum engine. No dependencies; imported by strm_build and the top level.
package strm_pkg;

  // Fixed field widths of the item and result channels
  localparam int MODE_W   = 2;
  localparam int INDEX_W  = 10;
  localparam int VALUE_W  = 16;
  localparam int RANGE_W  = 10;
  localparam int POS_W    = 10;
  localparam int STATUS_W = 2;
  localparam int CFG_W    = 11;

  // Default sizing
  localparam int DEF_MAX_ENTRIES = 1024;
  localparam int DEF_VALUE_BITS  = 16;
  localparam int DEF_LOG_LEVELS  = 11;

  localparam logic [CFG_W-1:0] TOUR_LENGTH_RESET = 11'd1024;

  // Item modes
  localparam logic [MODE_W-1:0] MODE_LOAD  = 2'd0;
  localparam logic [MODE_W-1:0] MODE_BUILD = 2'd1;
  localparam logic [MODE_W-1:0] MODE_QUERY = 2'd2;

  // Result kinds
  localparam logic KIND_BUILD = 1'b0;
  localparam logic KIND_QUERY = 1'b1;

  // Result status codes
  localparam logic [STATUS_W-1:0] STAT_OK        = 2'd0;
  localparam logic [STATUS_W-1:0] STAT_BAD_RANGE = 2'd1;
  localparam logic [STATUS_W-1:0] STAT_NOT_BUILT = 2'd2;

  // Top-level item sequencer
  typedef enum logic [2:0] {
    TS_IDLE,
    TS_BUILD,
    TS_Q_CHECK,
    TS_Q_TABLE,
    TS_Q_VALUE,
    TS_Q_COMPARE,
    TS_RESULT
  } top_state_t;

  // Table build sequencer
  typedef enum logic [2:0] {
    BL_IDLE,
    BL_LEVEL0,
    BL_ISSUE,
    BL_DRAIN,
    BL_DONE
  } bld_state_t;

  // Build engine status toward the top level
  typedef struct packed {
    logic busy;
    logic done;
  } bld_stat_t;

  // Index of the highest set bit; zero for zero
  function automatic logic [4:0] floor_log2(input logic [31:0] x);
    logic [4:0] r;
    r = 5'd0;
    for (int b = 0; b < 32; b++) begin
      if (x[b]) begin
        r = 5'(b);
      end
    end
    return r;
  endfunction

endpackage

[hw/rtl/strm_ram.sv]
// Synchronous RAM, one write port and two read ports, registered read data.
// Uses nothing from the package.
module strm_ram #(
  parameter int DEPTH = 1024,
  parameter int DW    = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [DW-1:0]            wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr0,
  input  logic [$clog2(DEPTH)-1:0] raddr1,
  output logic [DW-1:0]            rdata0,
  output logic [DW-1:0]            rdata1
);

  logic [DW-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // two read ports, registered read data
  always_ff @(posedge clk) begin
    rdata0 <= mem[raddr0];
    rdata1 <= mem[raddr1];
  end

endmodule

[hw/rtl/strm_build.sv]
// Table build engine: walks the doubling table level by level through a
// three-stage read/read/write pipeline. Depends on strm_pkg.
module strm_build #(
  parameter int MAX_ENTRIES = strm_pkg::DEF_MAX_ENTRIES,
  parameter int LOG_LEVELS  = strm_pkg::DEF_LOG_LEVELS,
  parameter int VALUE_BITS  = strm_pkg::DEF_VALUE_BITS
) (
  input  logic                                   clk,
  input  logic                                   rst,
  input  logic                                   start,
  input  logic [$clog2(MAX_ENTRIES+1)-1:0]       len,
  output strm_pkg::bld_stat_t                    stat,
  output logic                                   tbl_we,
  output logic [$clog2(MAX_ENTRIES*LOG_LEVELS)-1:0] tbl_waddr,
  output logic [$clog2(MAX_ENTRIES)-1:0]         tbl_wdata,
  output logic [$clog2(MAX_ENTRIES*LOG_LEVELS)-1:0] tbl_raddr0,
  output logic [$clog2(MAX_ENTRIES*LOG_LEVELS)-1:0] tbl_raddr1,
  input  logic [$clog2(MAX_ENTRIES)-1:0]         tbl_rdata0,
  input  logic [$clog2(MAX_ENTRIES)-1:0]         tbl_rdata1,
  output logic [$clog2(MAX_ENTRIES)-1:0]         val_raddr0,
  output logic [$clog2(MAX_ENTRIES)-1:0]         val_raddr1,
  input  logic [VALUE_BITS-1:0]                  val_rdata0,
  input  logic [VALUE_BITS-1:0]                  val_rdata1
);
  import strm_pkg::*;

  localparam int POS_BITS = $clog2(MAX_ENTRIES);
  localparam int LEN_BITS = $clog2(MAX_ENTRIES + 1);
  localparam int TBL_AW   = $clog2(MAX_ENTRIES * LOG_LEVELS);
  localparam int LVL_BITS = $clog2(LOG_LEVELS);

  bld_state_t state, state_next;

  logic [POS_BITS-1:0] i;
  logic [POS_BITS-1:0] lim;        // last start position of this level
  logic [LVL_BITS-1:0] lvl;
  logic [LEN_BITS:0]   span;       // 2^lvl
  logic [TBL_AW-1:0]   rd_base;    // row base of level lvl-1
  logic [TBL_AW-1:0]   wr_base;    // row base of level lvl

  // pipeline: stage 1 holds table read data, stage 2 value read data
  logic                v1, v2;
  logic [TBL_AW-1:0]   w1addr, w2addr;
  logic [POS_BITS-1:0] pa, pb;

  logic [LEN_BITS:0]   nxt_span;
  logic                more;
  logic                at_lim;
  logic                empty;
  logic                adv;
  logic [POS_BITS-1:0] half;

  // level bookkeeping
  always_comb begin
    nxt_span = span << 1;
    more     = (32'(lvl) + 1 < LOG_LEVELS) && (nxt_span <= (LEN_BITS+1)'(len));
    at_lim   = (i == lim);
    empty    = !v1 && !v2;
    adv      = more && (((state == BL_LEVEL0) && at_lim) || ((state == BL_DRAIN) && empty));
    half     = POS_BITS'(span >> 1);
  end

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      BL_IDLE: begin
        if (start) begin
          state_next = (len == '0) ? BL_DONE : BL_LEVEL0;
        end
      end
      BL_LEVEL0: begin
        if (at_lim) begin
          state_next = more ? BL_ISSUE : BL_DONE;
        end
      end
      BL_ISSUE: begin
        if (at_lim) begin
          state_next = BL_DRAIN;
        end
      end
      BL_DRAIN: begin
        if (empty) begin
          state_next = more ? BL_ISSUE : BL_DONE;
        end
      end
      BL_DONE: state_next = BL_IDLE;
      default: state_next = BL_IDLE;
    endcase
  end

  // memory ports and status
  always_comb begin
    stat.busy  = (state != BL_IDLE);
    stat.done  = (state == BL_DONE);
    tbl_raddr0 = rd_base + TBL_AW'(i);
    tbl_raddr1 = rd_base + TBL_AW'(i) + TBL_AW'(half);
    val_raddr0 = tbl_rdata0;
    val_raddr1 = tbl_rdata1;
    tbl_we     = (state == BL_LEVEL0) || v2;
    if (v2) begin
      tbl_waddr = w2addr;
      // right half wins on equal values
      tbl_wdata = (val_rdata0 < val_rdata1) ? pa : pb;
    end else begin
      tbl_waddr = wr_base + TBL_AW'(i);
      tbl_wdata = i;
    end
  end

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= BL_IDLE;
      v1    <= 1'b0;
      v2    <= 1'b0;
    end else begin
      state <= state_next;
      v1    <= (state == BL_ISSUE);
      v2    <= v1;
    end
  end

  // sweep counters and pipeline payload
  always_ff @(posedge clk) begin
    if ((state == BL_IDLE) && start) begin
      i       <= '0;
      lvl     <= '0;
      span    <= (LEN_BITS+1)'(1);
      rd_base <= '0;
      wr_base <= '0;
      lim     <= POS_BITS'(len - LEN_BITS'(1));
    end else if (adv) begin
      i       <= '0;
      lvl     <= lvl + LVL_BITS'(1);
      span    <= nxt_span;
      rd_base <= wr_base;
      wr_base <= wr_base + TBL_AW'(MAX_ENTRIES);
      lim     <= POS_BITS'(len - LEN_BITS'(nxt_span));
    end else if (((state == BL_LEVEL0) || (state == BL_ISSUE)) && !at_lim) begin
      i <= i + POS_BITS'(1);
    end
    w1addr <= wr_base + TBL_AW'(i);
    w2addr <= w1addr;
    pa     <= tbl_rdata0;
    pb     <= tbl_rdata1;
  end

`ifndef ASSERT_OFF
  a_start_idle: assert property (@(posedge clk) disable iff (rst)
    start |-> state == BL_IDLE)
    else $error("build started while busy");

  a_idle_empty: assert property (@(posedge clk) disable iff (rst)
    state == BL_IDLE |-> !v1 && !v2)
    else $error("build pipeline not empty at idle");

  a_level0_no_pipe: assert property (@(posedge clk) disable iff (rst)
    state == BL_LEVEL0 |-> !v2)
    else $error("table write port contention in level 0");
`endif

endmodule

[hw/rtl/sparse_table_range_min.sv]
// Top level of the sparse-table range-minimum engine: item sequencer,
// query datapath, value and table memories. Depends on strm_pkg, strm_ram, strm_build.
//
// A load is written on its transfer and the block is ready again at once. A
// query runs through range check and log2, one table read pair, one value
// read pair, compare, result register and the return to idle; a flagged query
// goes from the range check straight to the result register. Either one waits
// in the result state while an older result is still held on the output. A build
// with length L sweeps level 0 over all L positions, then for each level j below
// LOG_LEVELS with 2^j <= L issues the start positions 0 to L - 2^j and
// drains the read/read/write pipeline before the next level; the finished
// result is then registered on the output. The value
// store and the table come up undefined and need no clearing after reset;
// a build must only cover loaded positions.
module sparse_table_range_min #(
  parameter int MAX_ENTRIES = strm_pkg::DEF_MAX_ENTRIES,
  parameter int VALUE_BITS  = strm_pkg::DEF_VALUE_BITS,
  parameter int LOG_LEVELS  = strm_pkg::DEF_LOG_LEVELS
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_write,
  input  logic [strm_pkg::CFG_W-1:0]     cfg_data,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic [strm_pkg::MODE_W-1:0]    mode,
  input  logic [strm_pkg::INDEX_W-1:0]   entry_index,
  input  logic [strm_pkg::VALUE_W-1:0]   entry_value,
  input  logic [strm_pkg::RANGE_W-1:0]   range_low,
  input  logic [strm_pkg::RANGE_W-1:0]   range_high,
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic                           result_kind,
  output logic [strm_pkg::POS_W-1:0]     min_position,
  output logic [strm_pkg::STATUS_W-1:0]  status
);
  import strm_pkg::*;

  localparam int POS_BITS  = $clog2(MAX_ENTRIES);
  localparam int LEN_BITS  = $clog2(MAX_ENTRIES + 1);
  localparam int TBL_DEPTH = MAX_ENTRIES * LOG_LEVELS;
  localparam int TBL_AW    = $clog2(TBL_DEPTH);
  localparam int LVL_BITS  = $clog2(LOG_LEVELS);

  top_state_t state, state_next;

  logic [CFG_W-1:0]    tour_length;
  logic                built;
  logic [LEN_BITS-1:0] used_len;

  // query registers
  logic [RANGE_W-1:0]  q_lo, q_hi;
  logic [RANGE_W-1:0]  q_pos2;
  logic [LVL_BITS-1:0] q_k;
  logic [POS_BITS-1:0] q_p1, q_p2;

  // result hold and output register
  logic                res_kind;
  logic [POS_BITS-1:0] res_pos;
  logic [STATUS_W-1:0] res_status;

  // range check
  logic [STATUS_W-1:0] chk_status;
  logic [RANGE_W:0]    chk_span;
  logic [31:0]         chk_k;
  logic [RANGE_W:0]    chk_pos2;

  // control outputs
  logic                in_xfer;
  logic                load_we;
  logic                bld_start;
  logic                out_load;
  logic                q_take_p2;

  // memory ports
  logic [POS_BITS-1:0]   val_raddr0, val_raddr1;
  logic [VALUE_BITS-1:0] val_rdata0, val_rdata1;
  logic [TBL_AW-1:0]     tbl_raddr0, tbl_raddr1;
  logic [POS_BITS-1:0]   tbl_rdata0, tbl_rdata1;

  // build engine ports
  bld_stat_t             bld_stat;
  logic                  bld_tbl_we;
  logic [TBL_AW-1:0]     bld_tbl_waddr;
  logic [POS_BITS-1:0]   bld_tbl_wdata;
  logic [TBL_AW-1:0]     bld_tbl_raddr0, bld_tbl_raddr1;
  logic [POS_BITS-1:0]   bld_val_raddr0, bld_val_raddr1;

  // length in use saturates at the store depth
  always_comb begin
    used_len = (32'(tour_length) > MAX_ENTRIES) ? LEN_BITS'(MAX_ENTRIES)
                                                : LEN_BITS'(tour_length);
  end

  // range check, level select and second window start
  always_comb begin
    chk_span = {1'b0, q_hi} - {1'b0, q_lo} + (RANGE_W+1)'(1);
    chk_k    = 32'(floor_log2(32'(chk_span)));
    if (chk_k >= LOG_LEVELS) begin
      chk_k = LOG_LEVELS - 1;
    end
    chk_pos2 = {1'b0, q_hi} + (RANGE_W+1)'(1) - ((RANGE_W+1)'(1) << chk_k);
    if (!built) begin
      chk_status = STAT_NOT_BUILT;
    end else if ((q_lo > q_hi) || (32'(q_hi) >= 32'(used_len))) begin
      chk_status = STAT_BAD_RANGE;
    end else begin
      chk_status = STAT_OK;
    end
  end

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      TS_IDLE: begin
        if (in_valid) begin
          unique case (mode)
            MODE_BUILD: state_next = TS_BUILD;
            MODE_QUERY: state_next = TS_Q_CHECK;
            default:    state_next = TS_IDLE;
          endcase
        end
      end
      TS_BUILD: begin
        if (bld_stat.done) begin
          state_next = TS_RESULT;
        end
      end
      TS_Q_CHECK:   state_next = (chk_status == STAT_OK) ? TS_Q_TABLE : TS_RESULT;
      TS_Q_TABLE:   state_next = TS_Q_VALUE;
      TS_Q_VALUE:   state_next = TS_Q_COMPARE;
      TS_Q_COMPARE: state_next = TS_RESULT;
      TS_RESULT: begin
        if (!out_valid || out_ready) begin
          state_next = TS_IDLE;
        end
      end
      default: state_next = TS_IDLE;
    endcase
  end

  // outputs of the sequencer and memory port selection
  always_comb begin
    in_ready  = (state == TS_IDLE);
    in_xfer   = in_valid && in_ready;
    load_we   = in_xfer && (mode == MODE_LOAD) && (32'(entry_index) < MAX_ENTRIES);
    bld_start = in_xfer && (mode == MODE_BUILD);
    out_load  = (state == TS_RESULT) && (!out_valid || out_ready);
    q_take_p2 = !(val_rdata0 <= val_rdata1);
    if (bld_stat.busy) begin
      tbl_raddr0 = bld_tbl_raddr0;
      tbl_raddr1 = bld_tbl_raddr1;
      val_raddr0 = bld_val_raddr0;
      val_raddr1 = bld_val_raddr1;
    end else begin
      tbl_raddr0 = TBL_AW'(q_k) * TBL_AW'(MAX_ENTRIES) + TBL_AW'(q_lo);
      tbl_raddr1 = TBL_AW'(q_k) * TBL_AW'(MAX_ENTRIES) + TBL_AW'(q_pos2);
      val_raddr0 = tbl_rdata0;
      val_raddr1 = tbl_rdata1;
    end
  end

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= TS_IDLE;
      tour_length <= TOUR_LENGTH_RESET;
      built       <= 1'b0;
      out_valid   <= 1'b0;
    end else begin
      state <= state_next;
      if (cfg_write) begin
        tour_length <= cfg_data;
      end
      if (cfg_write || load_we) begin
        built <= 1'b0;
      end else if (bld_stat.done) begin
        built <= 1'b1;
      end
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // query and result payload
  always_ff @(posedge clk) begin
    if (in_xfer) begin
      q_lo <= range_low;
      q_hi <= range_high;
    end
    if (state == TS_Q_CHECK) begin
      q_k    <= LVL_BITS'(chk_k);
      q_pos2 <= RANGE_W'(chk_pos2);
    end
    if (state == TS_Q_VALUE) begin
      q_p1 <= tbl_rdata0;
      q_p2 <= tbl_rdata1;
    end
    priority case (1'b1)
      (state == TS_BUILD): begin
        res_kind   <= KIND_BUILD;
        res_pos    <= '0;
        res_status <= STAT_OK;
      end
      (state == TS_Q_CHECK): begin
        res_kind   <= KIND_QUERY;
        res_pos    <= '0;
        res_status <= chk_status;
      end
      (state == TS_Q_COMPARE): begin
        // first read wins on equal values
        res_pos <= q_take_p2 ? q_p2 : q_p1;
      end
      default: ;
    endcase
    if (out_load) begin
      result_kind  <= res_kind;
      min_position <= POS_W'(res_pos);
      status       <= res_status;
    end
  end

  strm_ram #(
    .DEPTH (MAX_ENTRIES),
    .DW    (VALUE_BITS)
  ) u_value_ram (
    .clk    (clk),
    .we     (load_we),
    .waddr  (POS_BITS'(entry_index)),
    .wdata  (VALUE_BITS'(entry_value)),
    .raddr0 (val_raddr0),
    .raddr1 (val_raddr1),
    .rdata0 (val_rdata0),
    .rdata1 (val_rdata1)
  );

  strm_ram #(
    .DEPTH (TBL_DEPTH),
    .DW    (POS_BITS)
  ) u_table_ram (
    .clk    (clk),
    .we     (bld_tbl_we),
    .waddr  (bld_tbl_waddr),
    .wdata  (bld_tbl_wdata),
    .raddr0 (tbl_raddr0),
    .raddr1 (tbl_raddr1),
    .rdata0 (tbl_rdata0),
    .rdata1 (tbl_rdata1)
  );

  strm_build #(
    .MAX_ENTRIES (MAX_ENTRIES),
    .LOG_LEVELS  (LOG_LEVELS),
    .VALUE_BITS  (VALUE_BITS)
  ) u_build (
    .clk        (clk),
    .rst        (rst),
    .start      (bld_start),
    .len        (used_len),
    .stat       (bld_stat),
    .tbl_we     (bld_tbl_we),
    .tbl_waddr  (bld_tbl_waddr),
    .tbl_wdata  (bld_tbl_wdata),
    .tbl_raddr0 (bld_tbl_raddr0),
    .tbl_raddr1 (bld_tbl_raddr1),
    .tbl_rdata0 (tbl_rdata0),
    .tbl_rdata1 (tbl_rdata1),
    .val_raddr0 (bld_val_raddr0),
    .val_raddr1 (bld_val_raddr1),
    .val_rdata0 (val_rdata0),
    .val_rdata1 (val_rdata1)
  );

`ifndef ASSERT_OFF
  a_ready_not_building: assert property (@(posedge clk) disable iff (rst)
    in_ready |-> !bld_stat.busy)
    else $error("input ready while build engine busy");

  a_build_starts: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready && mode == MODE_BUILD) |=> bld_stat.busy)
    else $error("build transfer did not start the build engine");

  a_query_built: assert property (@(posedge clk) disable iff (rst)
    state == TS_Q_TABLE |-> built)
    else $error("table read issued on an unbuilt table");

  a_build_result: assert property (@(posedge clk) disable iff (rst)
    (out_valid && result_kind == KIND_BUILD) |-> status == STAT_OK && min_position == '0)
    else $error("build result carries query fields");
`endif

endmodule
